/* sv/dss_pkg.sv */
// Package for the drum step sequencer: request codes, voice trigger types
// and the reset and default constants. No dependencies.
package dss_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_START   = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_SWING   = 3'd3,
    REQ_MUTE    = 3'd4,
    REQ_PATTERN = 3'd5
  } req_type_e;

  // Hat group codes, first set bit wins.
  typedef enum logic [1:0] {
    HAT_NONE = 2'd0,
    HAT_A    = 2'd1,
    HAT_B    = 2'd2
  } hat_sel_e;

  // Tom group codes, first set bit wins.
  typedef enum logic [1:0] {
    TOM_NONE = 2'd0,
    TOM_1    = 2'd1,
    TOM_2    = 2'd2,
    TOM_3    = 2'd3
  } tom_sel_e;

  localparam int unsigned VoiceW    = 9;
  localparam int unsigned PatW      = 4;
  localparam int unsigned StepOutW  = 4;
  localparam int unsigned LenW      = 16;
  localparam int unsigned WaitW     = 17;

  localparam int unsigned StepsDef        = 16;
  localparam int unsigned PatternCountDef = 16;

  localparam logic [LenW-1:0] PauseLenRst = 16'd125;
  localparam logic [3:0]      MuteIdxMax  = 4'd8;

  // Reciprocal of three: floor(x * 43691 / 2^17) == x / 3 for x below 2^17.
  localparam logic [LenW-1:0] ThirdRecip = 16'hAAAB;
  localparam int unsigned     ThirdShift = 17;

  // Decoded voice triggers of one played step.
  typedef struct packed {
    logic     kick;
    logic     snare;
    hat_sel_e hat_select;
    tom_sel_e tom_select;
    logic     bell;
    logic     shaker;
  } voices_t;

endpackage

/* sv/dss_req_if.sv */
// Request channel of the drum step sequencer: valid/ready plus one request item.
// Depends on nothing.
interface dss_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [8:0] step_bits;
  logic [3:0] mute_index;
  logic [3:0] pattern_number;

  modport source (output valid, req_type, step_bits, mute_index, pattern_number,
                  input ready);
  modport sink (input valid, req_type, step_bits, mute_index, pattern_number,
                output ready);
endinterface

/* sv/dss_res_if.sv */
// Result channel of the drum step sequencer: valid/ready plus one result item.
// Depends on nothing.
interface dss_res_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic       kick;
  logic       snare;
  logic [1:0] hat_select;
  logic [1:0] tom_select;
  logic       bell;
  logic       shaker;
  logic [3:0] played_step;
  logic [3:0] next_step;
  logic [3:0] pattern_now;
  logic [8:0] mutes_now;
  logic       answer;

  modport source (output valid, fired, kick, snare, hat_select, tom_select, bell,
                  shaker, played_step, next_step, pattern_now, mutes_now, answer,
                  input ready);
  modport sink (input valid, fired, kick, snare, hat_select, tom_select, bell,
                shaker, played_step, next_step, pattern_now, mutes_now, answer,
                output ready);
endinterface

/* sv/dss_wait_calc.sv */
// Step wait calculation: straight or swung step length, minus one.
// Depends on dss_pkg.
module dss_wait_calc (
  input  logic [dss_pkg::LenW-1:0]  len_i,
  input  logic                      swing_i,
  input  logic                      odd_i,
  output logic [dss_pkg::WaitW-1:0] wait_o
);

  localparam int unsigned ProdW = 2 * dss_pkg::LenW + 1;

  logic [ProdW-1:0]           prod;
  logic [dss_pkg::LenW-2:0]   third;
  logic [dss_pkg::LenW-1:0]   triple;
  logic [1:0]                 rem;
  logic [dss_pkg::WaitW-1:0]  len_sel;

  // Divide by three through the reciprocal; the remainder is at most two.
  assign prod   = ProdW'(len_i) * ProdW'(dss_pkg::ThirdRecip);
  assign third  = prod[dss_pkg::ThirdShift +: (dss_pkg::LenW - 1)];
  assign triple = dss_pkg::LenW'({third, 1'b0}) + dss_pkg::LenW'(third);
  assign rem    = 2'(len_i - triple);

  // Without swing every step is L; with swing, even steps are long (L + L/3), odd steps short (2L/3).
  always_comb begin
    if (!swing_i) begin
      len_sel = dss_pkg::WaitW'(len_i);
    end else if (!odd_i) begin
      len_sel = dss_pkg::WaitW'(len_i) + dss_pkg::WaitW'(third);
    end else begin
      len_sel = dss_pkg::WaitW'({third, 1'b0}) + dss_pkg::WaitW'(rem == 2'd2);
    end
  end

  assign wait_o = (len_sel == '0) ? '0 : len_sel - dss_pkg::WaitW'(1);

endmodule

/* sv/dss_voice_decode.sv */
// Voice trigger decode of a masked trigger word, with priority inside the
// hat and tom groups. Depends on dss_pkg.
module dss_voice_decode (
  input  logic [dss_pkg::VoiceW-1:0] trig_i,
  output dss_pkg::voices_t           voices_o
);

  always_comb begin
    voices_o.kick   = trig_i[0];
    voices_o.snare  = trig_i[1];
    voices_o.bell   = trig_i[7];
    voices_o.shaker = trig_i[8];

    // Lower bit wins within the hat group.
    if (trig_i[2]) begin
      voices_o.hat_select = dss_pkg::HAT_A;
    end else if (trig_i[3]) begin
      voices_o.hat_select = dss_pkg::HAT_B;
    end else begin
      voices_o.hat_select = dss_pkg::HAT_NONE;
    end

    // Lower bit wins within the tom group.
    if (trig_i[4]) begin
      voices_o.tom_select = dss_pkg::TOM_1;
    end else if (trig_i[5]) begin
      voices_o.tom_select = dss_pkg::TOM_2;
    end else if (trig_i[6]) begin
      voices_o.tom_select = dss_pkg::TOM_3;
    end else begin
      voices_o.tom_select = dss_pkg::TOM_NONE;
    end
  end

endmodule

/* sv/drum_step_sequencer.sv */
// Drum step sequencer: a request item enters an input register; once the result
// register is free, the item updates the sequencer state and loads the result
// register. Every request item gives exactly one result item. Throughput is one
// item per clock while the sink takes every result; an item passes the input
// register and then the result register, and the result register holds the item
// until it is taken. The result register takes a new item whenever the current
// one is taken in the same cycle, so a stalled sink leaves at most two items in the block.
// Depends on dss_pkg, dss_req_if, dss_res_if, dss_wait_calc, dss_voice_decode.
module drum_step_sequencer #(
  parameter int unsigned STEPS         = dss_pkg::StepsDef,
  parameter int unsigned PATTERN_COUNT = dss_pkg::PatternCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dss_pkg::LenW-1:0] cfg_wdata_i,
  dss_req_if.sink                  req_i,
  dss_res_if.source                res_o
);

  localparam int unsigned StepW = $clog2(STEPS);
  localparam logic [StepW-1:0] LastStep = StepW'(STEPS - 1);
  localparam int unsigned PcW = dss_pkg::PatW + 1;

  // Configuration and sequencer state.
  logic [dss_pkg::LenW-1:0]   pause_len_q;
  logic                       running_q, running_d;
  logic                       swing_q, swing_d;
  logic [StepW-1:0]           step_q, step_d;
  logic [dss_pkg::WaitW-1:0]  wait_q, wait_d;
  logic [dss_pkg::VoiceW-1:0] active_mask_q, active_mask_d;
  logic [dss_pkg::VoiceW-1:0] pending_mask_q, pending_mask_d;
  logic [dss_pkg::PatW-1:0]   active_pat_q, active_pat_d;
  logic                       pend_valid_q, pend_valid_d;
  logic [dss_pkg::PatW-1:0]   pending_pat_q, pending_pat_d;

  // Input register.
  logic                       in_valid_q;
  logic [2:0]                 req_type_q;
  logic [dss_pkg::VoiceW-1:0] step_bits_q;
  logic [3:0]                 mute_index_q;
  logic [dss_pkg::PatW-1:0]   pattern_number_q;

  // Result register.
  logic                       out_valid_q;
  logic                       fired_q, fired_d;
  dss_pkg::voices_t           voices_q, voices_d;
  logic [StepW-1:0]           played_q, played_d;
  logic                       answer_q, answer_d;
  logic [dss_pkg::StepOutW-1:0] next_step_q;
  logic [dss_pkg::PatW-1:0]   pattern_now_q;
  logic [dss_pkg::VoiceW-1:0] mutes_now_q;

  logic                       advance;
  logic [dss_pkg::WaitW-1:0]  step_wait;
  logic [dss_pkg::VoiceW-1:0] trig;
  dss_pkg::voices_t           voices_dec;
  logic [dss_pkg::VoiceW-1:0] mute_bit;
  logic                       pat_ok;

  // Handshake: the item in the input register moves when the result slot frees.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_len_q <= dss_pkg::PauseLenRst;
    end else if (cfg_we_i) begin
      pause_len_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q       <= req_i.req_type;
      step_bits_q      <= req_i.step_bits;
      mute_index_q     <= req_i.mute_index;
      pattern_number_q <= req_i.pattern_number;
    end
  end

  // Wait of the current step and voice decode of the masked trigger word.
  dss_wait_calc u_wait_calc (
    .len_i   (pause_len_q),
    .swing_i (swing_q),
    .odd_i   (step_q[0]),
    .wait_o  (step_wait)
  );

  assign trig = step_bits_q & ~active_mask_q;

  dss_voice_decode u_voice_decode (
    .trig_i   (trig),
    .voices_o (voices_dec)
  );

  assign mute_bit = dss_pkg::VoiceW'(1) << mute_index_q;
  assign pat_ok   = (PcW'(pattern_number_q) < PcW'(PATTERN_COUNT))
                    && (pattern_number_q != active_pat_q);

  // Request handling and next state.
  always_comb begin
    running_d      = running_q;
    swing_d        = swing_q;
    step_d         = step_q;
    wait_d         = wait_q;
    active_mask_d  = active_mask_q;
    pending_mask_d = pending_mask_q;
    active_pat_d   = active_pat_q;
    pend_valid_d   = pend_valid_q;
    pending_pat_d  = pending_pat_q;
    fired_d        = 1'b0;
    voices_d       = '0;
    played_d       = '0;
    answer_d       = 1'b0;

    case (dss_pkg::req_type_e'(req_type_q))
      dss_pkg::REQ_TICK: begin
        if (running_q) begin
          if (wait_q != '0) begin
            wait_d = wait_q - dss_pkg::WaitW'(1);
          end else begin
            wait_d   = step_wait;
            fired_d  = 1'b1;
            played_d = step_q;
            voices_d = voices_dec;
            if (step_q == LastStep) begin
              // Bar wrap: pending mutes and pattern take effect.
              step_d         = '0;
              active_mask_d  = active_mask_q ^ pending_mask_q;
              pending_mask_d = '0;
              if (pend_valid_q) begin
                active_pat_d = pending_pat_q;
                pend_valid_d = 1'b0;
              end
            end else begin
              step_d = step_q + StepW'(1);
            end
          end
        end
      end
      dss_pkg::REQ_START: begin
        running_d = 1'b1;
        step_d    = '0;
        wait_d    = '0;
        answer_d  = 1'b1;
      end
      dss_pkg::REQ_STOP: begin
        running_d = 1'b0;
      end
      dss_pkg::REQ_SWING: begin
        swing_d  = !swing_q;
        answer_d = !swing_q;
      end
      dss_pkg::REQ_MUTE: begin
        if (mute_index_q <= dss_pkg::MuteIdxMax) begin
          if (running_q) begin
            pending_mask_d = pending_mask_q ^ mute_bit;
            answer_d       = |(pending_mask_d & mute_bit);
          end else begin
            active_mask_d = active_mask_q ^ mute_bit;
            answer_d      = |(active_mask_d & mute_bit);
          end
        end
      end
      dss_pkg::REQ_PATTERN: begin
        if (pat_ok) begin
          if (running_q) begin
            pending_pat_d = pattern_number_q;
            pend_valid_d  = 1'b1;
          end else begin
            active_pat_d = pattern_number_q;
          end
          answer_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state registers, updated as an item moves to the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q      <= 1'b0;
      swing_q        <= 1'b0;
      step_q         <= '0;
      wait_q         <= '0;
      active_mask_q  <= '0;
      pending_mask_q <= '0;
      active_pat_q   <= '0;
      pend_valid_q   <= 1'b0;
      pending_pat_q  <= '0;
    end else if (advance) begin
      running_q      <= running_d;
      swing_q        <= swing_d;
      step_q         <= step_d;
      wait_q         <= wait_d;
      active_mask_q  <= active_mask_d;
      pending_mask_q <= pending_mask_d;
      active_pat_q   <= active_pat_d;
      pend_valid_q   <= pend_valid_d;
      pending_pat_q  <= pending_pat_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fired_q       <= fired_d;
      voices_q      <= voices_d;
      played_q      <= played_d;
      answer_q      <= answer_d;
      next_step_q   <= dss_pkg::StepOutW'(step_d);
      pattern_now_q <= active_pat_d;
      mutes_now_q   <= active_mask_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.fired       = fired_q;
  assign res_o.kick        = voices_q.kick;
  assign res_o.snare       = voices_q.snare;
  assign res_o.hat_select  = voices_q.hat_select;
  assign res_o.tom_select  = voices_q.tom_select;
  assign res_o.bell        = voices_q.bell;
  assign res_o.shaker      = voices_q.shaker;
  assign res_o.played_step = dss_pkg::StepOutW'(played_q);
  assign res_o.next_step   = next_step_q;
  assign res_o.pattern_now = pattern_now_q;
  assign res_o.mutes_now   = mutes_now_q;
  assign res_o.answer      = answer_q;

endmodule

/* verif/drum_step_sequencer_checker.sv */
// Checker for the drum step sequencer: watches the request, result and register
// ports, predicts every result item and compares it field by field.
// Depends on dss_pkg, dss_req_if and dss_res_if.
module drum_step_sequencer_checker #(
  parameter int unsigned STEPS         = dss_pkg::StepsDef,
  parameter int unsigned PATTERN_COUNT = dss_pkg::PatternCountDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [dss_pkg::LenW-1:0] cfg_wdata_i,
  dss_req_if                       req_mon,
  dss_res_if                       res_mon,
  output int unsigned              fail_count_o,
  output int unsigned              beats_waiting_o
);

  // One predicted result item.
  typedef struct packed {
    logic                       fired;
    logic                       kick;
    logic                       snare;
    dss_pkg::hat_sel_e          hat_select;
    dss_pkg::tom_sel_e          tom_select;
    logic                       bell;
    logic                       shaker;
    logic [3:0]                 played_step;
    logic [3:0]                 next_step;
    logic [dss_pkg::PatW-1:0]   pattern_now;
    logic [dss_pkg::VoiceW-1:0] mutes_now;
    logic                       answer;
  } beat_t;

  // Shadow of the sequencer state and its step length register.
  logic [dss_pkg::LenW-1:0]   step_len_ms;
  logic                       is_playing;
  logic                       swing_en;
  int unsigned                cur_step;
  int unsigned                ms_left;
  logic [dss_pkg::VoiceW-1:0] live_mutes;
  logic [dss_pkg::VoiceW-1:0] queued_mutes;
  logic [dss_pkg::PatW-1:0]   live_pattern;
  logic                       pattern_queued;
  logic [dss_pkg::PatW-1:0]   queued_pattern;

  beat_t       beats_due[$];
  int unsigned fail_count;

  assign fail_count_o = fail_count;

  // Wait loaded after a step fires: straight, or long on even and short on odd
  // steps when swing is on.
  function automatic int unsigned step_pause(int unsigned step);
    int unsigned len;
    int unsigned w;
    len = step_len_ms;
    if (!swing_en) begin
      w = len;
    end else if (step % 2 == 0) begin
      w = len + len / 3;
    end else begin
      w = (2 * len) / 3;
    end
    return (w > 0) ? w - 1 : 0;
  endfunction

  // Applies one request item to the shadow state and returns its result item.
  function automatic beat_t play_request(logic [2:0] op,
                                         logic [dss_pkg::VoiceW-1:0] bits,
                                         logic [3:0] midx,
                                         logic [dss_pkg::PatW-1:0] pnum);
    beat_t                      r;
    logic [dss_pkg::VoiceW-1:0] word;
    logic [dss_pkg::VoiceW-1:0] voice_bit;
    r = '0;
    case (op)
      dss_pkg::REQ_TICK: begin
        if (is_playing && ms_left != 0) begin
          ms_left = ms_left - 1;
        end else if (is_playing) begin
          word = bits & ~live_mutes;
          ms_left = step_pause(cur_step);
          r.fired       = 1'b1;
          r.played_step = cur_step[3:0];
          r.kick        = word[0];
          r.snare       = word[1];
          r.hat_select  = word[2] ? dss_pkg::HAT_A
                        : (word[3] ? dss_pkg::HAT_B : dss_pkg::HAT_NONE);
          r.tom_select  = word[4] ? dss_pkg::TOM_1
                        : (word[5] ? dss_pkg::TOM_2
                        : (word[6] ? dss_pkg::TOM_3 : dss_pkg::TOM_NONE));
          r.bell        = word[7];
          r.shaker      = word[8];
          // The bar wrap is where held mute and pattern changes land.
          if (cur_step + 1 >= STEPS) begin
            cur_step = 0;
            live_mutes = live_mutes ^ queued_mutes;
            queued_mutes = '0;
            if (pattern_queued) begin
              live_pattern = queued_pattern;
              pattern_queued = 1'b0;
            end
          end else begin
            cur_step = cur_step + 1;
          end
        end
      end
      dss_pkg::REQ_START: begin
        is_playing = 1'b1;
        cur_step = 0;
        ms_left = 0;
        r.answer = 1'b1;
      end
      dss_pkg::REQ_STOP: begin
        is_playing = 1'b0;
      end
      dss_pkg::REQ_SWING: begin
        swing_en = !swing_en;
        r.answer = swing_en;
      end
      dss_pkg::REQ_MUTE: begin
        if (midx <= dss_pkg::MuteIdxMax) begin
          voice_bit = dss_pkg::VoiceW'(1) << midx;
          if (is_playing) begin
            queued_mutes = queued_mutes ^ voice_bit;
            r.answer = |(queued_mutes & voice_bit);
          end else begin
            live_mutes = live_mutes ^ voice_bit;
            r.answer = |(live_mutes & voice_bit);
          end
        end
      end
      dss_pkg::REQ_PATTERN: begin
        if (pnum < PATTERN_COUNT && pnum != live_pattern) begin
          if (is_playing) begin
            queued_pattern = pnum;
            pattern_queued = 1'b1;
          end else begin
            live_pattern = pnum;
          end
          r.answer = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.next_step   = cur_step[3:0];
    r.pattern_now = live_pattern;
    r.mutes_now   = live_mutes;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Track the register, predict accepted requests and compare accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      step_len_ms     = dss_pkg::PauseLenRst;
      is_playing      = 1'b0;
      swing_en        = 1'b0;
      cur_step        = 0;
      ms_left         = 0;
      live_mutes      = '0;
      queued_mutes    = '0;
      live_pattern    = '0;
      pattern_queued  = 1'b0;
      queued_pattern  = '0;
      beats_due.delete();
      fail_count      = 0;
      beats_waiting_o = 0;
    end else begin
      if (cfg_we_i) begin
        step_len_ms = cfg_wdata_i;
      end
      if (req_mon.valid && req_mon.ready) begin
        beats_due.push_back(play_request(req_mon.req_type, req_mon.step_bits,
                                         req_mon.mute_index, req_mon.pattern_number));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (beats_due.size() == 0) begin
          $error("result item arrived with no expected item waiting");
          fail_count++;
        end else begin
          want = beats_due.pop_front();
          check_field("fired", want.fired, res_mon.fired);
          check_field("kick", want.kick, res_mon.kick);
          check_field("snare", want.snare, res_mon.snare);
          check_field("hat_select", want.hat_select, res_mon.hat_select);
          check_field("tom_select", want.tom_select, res_mon.tom_select);
          check_field("bell", want.bell, res_mon.bell);
          check_field("shaker", want.shaker, res_mon.shaker);
          check_field("played_step", want.played_step, res_mon.played_step);
          check_field("next_step", want.next_step, res_mon.next_step);
          check_field("pattern_now", want.pattern_now, res_mon.pattern_now);
          check_field("mutes_now", want.mutes_now, res_mon.mutes_now);
          check_field("answer", want.answer, res_mon.answer);
        end
      end
      beats_waiting_o = beats_due.size();
    end
  end

endmodule

/* verif/drum_step_sequencer_tb.sv */
// Testbench top for the drum step sequencer: clock, reset, request and register
// stimulus, random result back-pressure, watchdog and verdict.
// Depends on dss_pkg, the channel interfaces, the block and its checker.
module drum_step_sequencer_tb;

  // Request codes the block must ignore.
  localparam logic [2:0] ReqUnusedLo = 3'd6;
  localparam logic [2:0] ReqUnusedHi = 3'd7;

  localparam int unsigned HoldCycles    = 48;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseCount    = 6;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [dss_pkg::LenW-1:0] cfg_wdata;
  int unsigned              fail_count;
  int unsigned              beats_waiting;
  int unsigned              send_idle_pct;
  int unsigned              recv_idle_pct;
  int unsigned              hold_reqs;
  int unsigned              holds_done;
  int unsigned              stall_cycles;

  dss_req_if req_if ();
  dss_res_if res_if ();

  drum_step_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  drum_step_sequencer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .req_mon         (req_if),
    .res_mon         (res_if),
    .fail_count_o    (fail_count),
    .beats_waiting_o (beats_waiting)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    res_if.ready = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        res_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      res_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Offers one request item, with a random gap first, and returns after it is
  // accepted. Valid stays high so that a following item goes out back to back.
  task automatic send_item(input logic [2:0] op,
                           input logic [dss_pkg::VoiceW-1:0] bits,
                           input logic [3:0] midx,
                           input logic [dss_pkg::PatW-1:0] pnum);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid          = 1'b1;
    req_if.req_type       = op;
    req_if.step_bits      = bits;
    req_if.mute_index     = midx;
    req_if.pattern_number = pnum;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drains the block, then writes the step length register.
  task automatic set_step_length(input logic [dss_pkg::LenW-1:0] ms);
    req_if.valid = 1'b0;
    while (beats_waiting != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_wdata = ms;
    cfg_we = 1'b1;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Mostly ticks of a running sequence, with button presses mixed in.
  task automatic send_random_item();
    int unsigned roll;
    logic [2:0]  op;
    logic [3:0]  midx;
    roll = $urandom_range(99);
    if (roll < 66) begin
      op = dss_pkg::REQ_TICK;
    end else if (roll < 72) begin
      op = dss_pkg::REQ_START;
    end else if (roll < 75) begin
      op = dss_pkg::REQ_STOP;
    end else if (roll < 80) begin
      op = dss_pkg::REQ_SWING;
    end else if (roll < 88) begin
      op = dss_pkg::REQ_MUTE;
    end else if (roll < 97) begin
      op = dss_pkg::REQ_PATTERN;
    end else begin
      op = $urandom_range(1) ? ReqUnusedHi : ReqUnusedLo;
    end
    midx = ($urandom_range(3) != 0) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
    send_item(op, 9'($urandom), midx, 4'($urandom));
  endtask

  initial begin
    logic [dss_pkg::LenW-1:0] phase_len[PhaseCount];
    int unsigned              phase_items[PhaseCount];
    phase_len   = '{16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd1, 16'd5};
    phase_items = '{240, 240, 60, 240, 240, 240};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = dss_pkg::PauseLenRst;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs = 0;
    stall_cycles = 0;
    req_if.valid = 1'b0;
    req_if.req_type = dss_pkg::REQ_TICK;
    req_if.step_bits = '0;
    req_if.mute_index = '0;
    req_if.pattern_number = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with a one millisecond step, so every running tick fires.
    set_step_length(16'd1);
    send_item(dss_pkg::REQ_TICK, 9'h1FF, 4'd0, 4'd0);      // tick while stopped
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd8, 4'd0);      // highest voice
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd9, 4'd0);      // rejected index
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd15, 4'd0);     // rejected index
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd0, 4'd0);      // unmute again
    send_item(dss_pkg::REQ_PATTERN, 9'h000, 4'd0, 4'd0);   // same as active, rejected
    send_item(dss_pkg::REQ_PATTERN, 9'h000, 4'd0, 4'd15);
    send_item(dss_pkg::REQ_SWING, 9'h000, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_SWING, 9'h000, 4'd0, 4'd0);
    send_item(ReqUnusedLo, 9'h1FF, 4'd15, 4'd15);
    send_item(ReqUnusedHi, 9'h1FF, 4'd15, 4'd15);
    send_item(dss_pkg::REQ_START, 9'h000, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_TICK, 9'h1FF, 4'd0, 4'd0);      // all voices, shaker muted
    send_item(dss_pkg::REQ_TICK, 9'h00C, 4'd0, 4'd0);      // both hats, first wins
    send_item(dss_pkg::REQ_TICK, 9'h008, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_TICK, 9'h070, 4'd0, 4'd0);      // all toms, first wins
    send_item(dss_pkg::REQ_TICK, 9'h060, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_TICK, 9'h040, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_MUTE, 9'h000, 4'd1, 4'd0);      // held until the bar wraps
    send_item(dss_pkg::REQ_PATTERN, 9'h000, 4'd0, 4'd3);
    send_item(dss_pkg::REQ_PATTERN, 9'h000, 4'd0, 4'd7);   // replaces the held one
    send_item(dss_pkg::REQ_START, 9'h000, 4'd0, 4'd0);     // restart while running
    send_item(dss_pkg::REQ_STOP, 9'h000, 4'd0, 4'd0);
    send_item(dss_pkg::REQ_TICK, 9'h1FF, 4'd0, 4'd0);

    // Random part, one step length and one idling pattern per phase.
    for (int p = 0; p < PhaseCount; p++) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_step_length(phase_len[p]);
      if (p < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 85;
      end else if (p < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 26;
      end else if (p == 4) begin
        // Long result stall while requests keep coming, to fill the block.
        hold_reqs++;
      end
      send_item(dss_pkg::REQ_START, 9'($urandom), 4'($urandom), 4'($urandom));
      for (int i = 0; i < phase_items[p]; i++) begin
        send_random_item();
      end
    end

    req_if.valid = 1'b0;
    while (beats_waiting != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* drum_step_sequencer.f */
sv/dss_pkg.sv
sv/dss_req_if.sv
sv/dss_res_if.sv
sv/dss_wait_calc.sv
sv/dss_voice_decode.sv
sv/drum_step_sequencer.sv
verif/drum_step_sequencer_checker.sv
verif/drum_step_sequencer_tb.sv
